// ----- rtl/prim_mst_pkg.sv -----
// Shared types and constants for the Prim spanning tree core.
`default_nettype none
package prim_mst_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [13:0] NO_EDGE     = 14'd9999;
  localparam logic [17:0] TOTAL_LIMIT = 18'd149985;
  localparam logic [4:0]  VCOUNT_RST  = 5'd16;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [13:0] edge_weight;
    logic        last_entry;
  } mst_in_t;

  typedef struct packed {
    logic [3:0]  new_vertex;
    logic [3:0]  attach_vertex;
    logic [13:0] edge_cost;
    logic [17:0] total_cost;
    logic        unreachable;
    logic        last_edge;
  } mst_out_t;

endpackage
`default_nettype wire

// ----- rtl/prim_mst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prim_mst_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/prim_minimum_spanning_tree_core.sv -----
// Top level of the Prim minimum spanning tree core over a loaded cost matrix.
//
//  Channel   Signals                     Direction  Transfer
//  --------  --------------------------  ---------  ------------------------------------
//  input     start, busy, item           in         start high while busy is low
//  result    result_valid, result        out        every cycle result_valid is high
//  config    cfg_wr_en, cfg_wr_data      in         every cycle cfg_wr_en is high
//
// The core stays ready while idle, so matrix entries stream in back to back. An
// entry marked last starts the tree computation, and busy stays high until the
// final tree edge has been issued. The computation is bounded by the single
// read port of the cost memory: a scan of all n*n entries for the first edge,
// a nearest-vertex setup, and per later edge a pick scan plus a nearest
// update, n being the clamped vertex count. Results cannot be stalled; each
// is shown for exactly one cycle. Reset is synchronous and clears the control
// state; the cost memory needs no clearing pass since every entry read in use
// must have been written before.
`default_nettype none
module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = prim_mst_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire prim_mst_pkg::mst_in_t  item,
  output logic                        result_valid,
  output prim_mst_pkg::mst_out_t      result,
  input  wire logic                   cfg_wr_en,
  input  wire logic [4:0]             cfg_wr_data
);

  // Vertex index width, counter width (holds the count itself) and memory size.
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = 1 << (2 * VW);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_F_RD  = 4'd1;
  localparam logic [3:0] S_F_EV  = 4'd2;
  localparam logic [3:0] S_F_END = 4'd3;
  localparam logic [3:0] S_I_RDA = 4'd4;
  localparam logic [3:0] S_I_EVA = 4'd5;
  localparam logic [3:0] S_I_RDB = 4'd6;
  localparam logic [3:0] S_I_EVB = 4'd7;
  localparam logic [3:0] S_P_RD  = 4'd8;
  localparam logic [3:0] S_P_EV  = 4'd9;
  localparam logic [3:0] S_P_END = 4'd10;
  localparam logic [3:0] S_U_RDA = 4'd11;
  localparam logic [3:0] S_U_EVA = 4'd12;
  localparam logic [3:0] S_U_RDB = 4'd13;
  localparam logic [3:0] S_U_EVB = 4'd14;

  logic [3:0]    state;
  logic [4:0]    vertex_count;
  logic [NW-1:0] n;
  logic [NW-1:0] idx;
  logic [NW-1:0] col;
  logic [NW-1:0] step;
  logic [13:0]   best;
  logic [13:0]   wa;
  logic [VW-1:0] a;
  logic [VW-1:0] b;
  logic [VW-1:0] pick;
  logic [VW-1:0] att;
  logic [VW-1:0] first_out;
  logic [VW-1:0] first_att;
  logic          found;
  logic          have_first;
  logic [17:0]   cost_sum;
  logic          in_tree [MAX_VERTICES];
  logic [VW-1:0] nearest [MAX_VERTICES];

  // Memory ports.
  logic              mem_we;
  logic [2*VW-1:0]   mem_waddr;
  logic [13:0]       mem_wdata;
  logic [2*VW-1:0]   mem_raddr;
  logic [13:0]       mem_rdata;

  // Derived control values.
  logic          accept;
  logic [NW-1:0] n_clamp;
  logic [NW-1:0] n_m1;
  logic [VW-1:0] iv;
  logic [VW-1:0] cv;
  logic [VW-1:0] near_i;
  logic          idx_last;
  logic          step_last;
  logic [17:0]   sum_base;
  logic [18:0]   sum_wide;
  logic [17:0]   sum_sat;
  logic          row_ok;
  logic          col_ok;
  logic [VW-1:0] p_vertex;
  logic [VW-1:0] p_attach;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign n_m1     = n - NW'(1);
  assign iv       = idx[VW-1:0];
  assign cv       = col[VW-1:0];
  assign near_i   = nearest[iv];
  assign idx_last = (idx == n_m1);
  assign step_last = (({1'b0, step} + (NW+1)'(2)) == {1'b0, n});
  assign p_vertex = found ? pick : first_out;
  assign p_attach = found ? att : first_att;

  // Vertex count clamped into its legal range when a computation begins.
  always_comb begin
    if (vertex_count < 5'd2) begin
      n_clamp = NW'(2);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_clamp = NW'(MAX_VERTICES);
    end else begin
      n_clamp = NW'(vertex_count);
    end
  end

  // Matrix load: writes outside the matrix are dropped, heavy weights mean no edge.
  assign row_ok    = (32'(item.row_index) < MAX_VERTICES);
  assign col_ok    = (32'(item.col_index) < MAX_VERTICES);
  assign mem_we    = accept && row_ok && col_ok;
  assign mem_waddr = {VW'(item.row_index), VW'(item.col_index)};
  assign mem_wdata = (item.edge_weight > prim_mst_pkg::NO_EDGE) ?
                     prim_mst_pkg::NO_EDGE : item.edge_weight;

  // One read per cycle; the address depends on which pass is running.
  always_comb begin
    case (state)
      S_F_RD:  mem_raddr = {iv, cv};
      S_I_RDA: mem_raddr = {iv, a};
      S_I_RDB: mem_raddr = {iv, b};
      S_P_RD:  mem_raddr = {iv, near_i};
      S_U_RDA: mem_raddr = {iv, pick};
      S_U_RDB: mem_raddr = {iv, near_i};
      default: mem_raddr = '0;
    endcase
  end

  // Running total, restarted on the first edge of each tree, saturating.
  assign sum_base = (state == S_F_END) ? 18'd0 : cost_sum;
  assign sum_wide = {1'b0, sum_base} + 19'(best);
  assign sum_sat  = (sum_wide > {1'b0, prim_mst_pkg::TOTAL_LIMIT}) ?
                    prim_mst_pkg::TOTAL_LIMIT : sum_wide[17:0];

  prim_mst_ram #(
    .WIDTH (14),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= prim_mst_pkg::VCOUNT_RST;
      result_valid <= 1'b0;
      cost_sum     <= '0;
      for (int k = 0; k < MAX_VERTICES; k++) begin
        in_tree[k] <= 1'b0;
        nearest[k] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end

      case (state)
        S_IDLE: begin
          if (accept && item.last_entry) begin
            n     <= n_clamp;
            idx   <= '0;
            col   <= '0;
            best  <= prim_mst_pkg::NO_EDGE;
            found <= 1'b0;
            a     <= '0;
            b     <= VW'(1);
            state <= S_F_RD;
          end
        end

        // First edge: cheapest off-diagonal entry in row-major order.
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          if (idx != col && mem_rdata < best) begin
            best  <= mem_rdata;
            a     <= iv;
            b     <= cv;
            found <= 1'b1;
          end
          if (col == n_m1) begin
            col <= '0;
            if (idx_last) begin
              state <= S_F_END;
            end else begin
              idx   <= idx + NW'(1);
              state <= S_F_RD;
            end
          end else begin
            col   <= col + NW'(1);
            state <= S_F_RD;
          end
        end
        S_F_END: begin
          result_valid          <= 1'b1;
          result.new_vertex     <= 4'(a);
          result.attach_vertex  <= 4'(b);
          result.edge_cost      <= best;
          result.total_cost     <= sum_sat;
          result.unreachable    <= !found;
          result.last_edge      <= (n == NW'(2));
          cost_sum              <= sum_sat;
          for (int k = 0; k < MAX_VERTICES; k++) begin
            in_tree[k] <= (VW'(k) == a) || (VW'(k) == b);
          end
          idx   <= '0;
          state <= (n == NW'(2)) ? S_IDLE : S_I_RDA;
        end

        // Nearest tree vertex for each vertex; ties go to the second endpoint.
        S_I_RDA: begin
          state <= S_I_EVA;
        end
        S_I_EVA: begin
          wa    <= mem_rdata;
          state <= S_I_RDB;
        end
        S_I_RDB: begin
          state <= S_I_EVB;
        end
        S_I_EVB: begin
          nearest[iv] <= (wa < mem_rdata) ? a : b;
          if (idx_last) begin
            step       <= NW'(1);
            idx        <= '0;
            best       <= prim_mst_pkg::NO_EDGE;
            found      <= 1'b0;
            have_first <= 1'b0;
            state      <= S_P_RD;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_I_RDA;
          end
        end

        // Pick scan: lowest-index outside vertex with strictly smallest cost.
        S_P_RD: begin
          if (in_tree[iv]) begin
            if (idx_last) begin
              state <= S_P_END;
            end else begin
              idx <= idx + NW'(1);
            end
          end else begin
            state <= S_P_EV;
          end
        end
        S_P_EV: begin
          if (!have_first) begin
            have_first <= 1'b1;
            first_out  <= iv;
            first_att  <= near_i;
          end
          if (mem_rdata < best) begin
            best  <= mem_rdata;
            pick  <= iv;
            att   <= near_i;
            found <= 1'b1;
          end
          if (idx_last) begin
            state <= S_P_END;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_P_RD;
          end
        end
        S_P_END: begin
          // With no finite edge left, the stored weight of the fallback edge is
          // the no-edge value, which is what best still holds.
          result_valid          <= 1'b1;
          result.new_vertex     <= 4'(p_vertex);
          result.attach_vertex  <= 4'(p_attach);
          result.edge_cost      <= best;
          result.total_cost     <= sum_sat;
          result.unreachable    <= !found;
          result.last_edge      <= step_last;
          cost_sum              <= sum_sat;
          in_tree[p_vertex]     <= 1'b1;
          pick                  <= p_vertex;
          idx                   <= '0;
          state                 <= step_last ? S_IDLE : S_U_RDA;
        end

        // Nearest update against the vertex just added.
        S_U_RDA: begin
          if (in_tree[iv]) begin
            if (idx_last) begin
              step       <= step + NW'(1);
              idx        <= '0;
              best       <= prim_mst_pkg::NO_EDGE;
              found      <= 1'b0;
              have_first <= 1'b0;
              state      <= S_P_RD;
            end else begin
              idx <= idx + NW'(1);
            end
          end else begin
            state <= S_U_EVA;
          end
        end
        S_U_EVA: begin
          wa    <= mem_rdata;
          state <= S_U_RDB;
        end
        S_U_RDB: begin
          state <= S_U_EVB;
        end
        S_U_EVB: begin
          if (wa < mem_rdata) begin
            nearest[iv] <= pick;
          end
          if (idx_last) begin
            step       <= step + NW'(1);
            idx        <= '0;
            best       <= prim_mst_pkg::NO_EDGE;
            found      <= 1'b0;
            have_first <= 1'b0;
            state      <= S_P_RD;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_U_RDA;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
